// File: rtl/faulty_memory_model_assert.svh
// Assertion macros used by the checker file of the faulty memory model.
`ifndef FAULTY_MEMORY_MODEL_ASSERT_SVH
`define FAULTY_MEMORY_MODEL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("faulty_memory_model: assertion failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define FMM_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
        else $error("faulty_memory_model: assertion failed");

`endif

// File: rtl/fmm_pkg.sv
// Package of the faulty memory model: sizes, codes and the update struct.
package fmm_pkg;

    localparam int WORDS     = 1024;
    localparam int WORD_BITS = 8;
    localparam int ADDR_W    = $clog2(WORDS);
    localparam int FC_W      = 4;
    localparam int FAULT_W   = WORD_BITS * FC_W;

    // Port widths of the transaction fields
    localparam int FUNC_PW  = 2;
    localparam int ADDR_PW  = 10;
    localparam int DATA_PW  = 8;
    localparam int BIT_PW   = 3;

    localparam logic [FUNC_PW-1:0] FUNC_READ      = 2'd0;
    localparam logic [FUNC_PW-1:0] FUNC_WRITE     = 2'd1;
    localparam logic [FUNC_PW-1:0] FUNC_SET_FAULT = 2'd2;

    localparam logic [FC_W-1:0] FC_NONE    = 4'd0;
    localparam logic [FC_W-1:0] FC_SA0     = 4'd1;
    localparam logic [FC_W-1:0] FC_SA1     = 4'd2;
    localparam logic [FC_W-1:0] FC_TF_UP   = 4'd3;
    localparam logic [FC_W-1:0] FC_TF_DOWN = 4'd4;
    localparam logic [FC_W-1:0] FC_RDF0    = 4'd5;
    localparam logic [FC_W-1:0] FC_RDF1    = 4'd6;
    localparam logic [FC_W-1:0] FC_IRF0    = 4'd7;
    localparam logic [FC_W-1:0] FC_IRF1    = 4'd8;
    localparam logic [FC_W-1:0] FC_DRDF0   = 4'd9;
    localparam logic [FC_W-1:0] FC_DRDF1   = 4'd10;

    typedef struct packed {
        logic                 data_we;
        logic [WORD_BITS-1:0] data_wdata;
        logic                 fault_we;
        logic [FAULT_W-1:0]   fault_wdata;
        logic                 rd_valid;
        logic [WORD_BITS-1:0] rd_word;
    } t_upd;

endpackage

// File: rtl/faulty_memory_model.sv
// Top level of the faulty memory model: command port, clearing pass and the two stores.
//
// Usage
//   Issue a transaction by raising start with the fields set; it is taken at a
//   rising edge where start is high and busy is low. i_func selects a word read,
//   a word write or setting the fault code of one cell (i_bit_index, i_fault_code).
//   A read returns o_read_data with o_read_valid high for exactly one cycle; the
//   receiver cannot stall, so capture it in that cycle. Writes and fault updates
//   return nothing.
// Timing
//   Each transaction reads both stores in the accept cycle, then modifies and
//   writes them back in the following cycle while busy is high. Because of the
//   registered read of the store RAMs ahead of the write-back, busy holds off
//   the next transaction until the write-back is done. The read strobe comes
//   from r_read_valid, registered from the write-back result, and is taken at
//   the edge that ends it.
// Reset
//   After reset, sweep both stores to zero, one word per cycle: busy stays high
//   until all WORDS (1024) words are cleared; no transaction is taken during it.
module faulty_memory_model (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fmm_pkg::FUNC_PW-1:0]  i_func,
    input  logic [fmm_pkg::ADDR_PW-1:0]  i_address,
    input  logic [fmm_pkg::DATA_PW-1:0]  i_write_data,
    input  logic [fmm_pkg::BIT_PW-1:0]   i_bit_index,
    input  logic [fmm_pkg::FC_W-1:0]     i_fault_code,
    output logic                         o_read_valid,
    output logic [fmm_pkg::DATA_PW-1:0]  o_read_data
);

    // Control state
    logic                        r_clearing, n_clearing;
    logic [fmm_pkg::ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic                        r_active, n_active;
    logic                        r_read_valid;

    // Captured transaction
    logic [fmm_pkg::FUNC_PW-1:0]   r_func;
    logic [fmm_pkg::ADDR_W-1:0]    r_addr;
    logic                          r_inside;
    logic [fmm_pkg::WORD_BITS-1:0] r_wdata;
    logic [fmm_pkg::BIT_PW-1:0]    r_bit;
    logic [fmm_pkg::FC_W-1:0]      r_code;
    logic [fmm_pkg::WORD_BITS-1:0] r_read_data;

    logic                          accept;
    logic [fmm_pkg::WORD_BITS-1:0] data_rd;
    logic [fmm_pkg::FAULT_W-1:0]   fault_rd;
    fmm_pkg::t_upd                 upd;

    logic                          data_we;
    logic                          fault_we;
    logic [fmm_pkg::ADDR_W-1:0]    waddr;
    logic [fmm_pkg::WORD_BITS-1:0] data_wdata;
    logic [fmm_pkg::FAULT_W-1:0]   fault_wdata;

    // Hold off new transactions during the sweep and the write-back cycle
    assign busy   = r_clearing || r_active;
    assign accept = start && !busy;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + fmm_pkg::ADDR_W'(1);
            if (r_clr_addr == fmm_pkg::ADDR_W'(fmm_pkg::WORDS - 1)) begin
                n_clearing = 1'b0;
            end
        end
        n_active = accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_active     <= 1'b0;
            r_read_valid <= 1'b0;
        end else begin
            r_clearing   <= n_clearing;
            r_clr_addr   <= n_clr_addr;
            r_active     <= n_active;
            r_read_valid <= upd.rd_valid;
        end
    end

    // Capture the fields on accept; register the read result for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_addr   <= i_address[fmm_pkg::ADDR_W-1:0];
            r_inside <= 32'(i_address) < fmm_pkg::WORDS;
            r_wdata  <= i_write_data[fmm_pkg::WORD_BITS-1:0];
            r_bit    <= i_bit_index;
            r_code   <= i_fault_code;
        end
        if (upd.rd_valid) begin
            r_read_data <= upd.rd_word;
        end
    end

    fmm_update u_update (
        .i_active (r_active),
        .i_inside (r_inside),
        .i_func   (r_func),
        .i_wdata  (r_wdata),
        .i_bit    (r_bit),
        .i_code   (r_code),
        .i_stored (data_rd),
        .i_faults (fault_rd),
        .o_upd    (upd)
    );

    // Write port: the clearing sweep owns it until done, then the write-back
    assign data_we     = r_clearing || upd.data_we;
    assign fault_we    = r_clearing || upd.fault_we;
    assign waddr       = r_clearing ? r_clr_addr : r_addr;
    assign data_wdata  = r_clearing ? '0 : upd.data_wdata;
    assign fault_wdata = r_clearing ? '0 : upd.fault_wdata;

    fmm_ram #(
        .WIDTH (fmm_pkg::WORD_BITS),
        .DEPTH (fmm_pkg::WORDS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (waddr),
        .i_wdata (data_wdata),
        .i_raddr (i_address[fmm_pkg::ADDR_W-1:0]),
        .o_rdata (data_rd)
    );

    fmm_ram #(
        .WIDTH (fmm_pkg::FAULT_W),
        .DEPTH (fmm_pkg::WORDS)
    ) u_fault_ram (
        .i_clk   (i_clk),
        .i_we    (fault_we),
        .i_waddr (waddr),
        .i_wdata (fault_wdata),
        .i_raddr (i_address[fmm_pkg::ADDR_W-1:0]),
        .o_rdata (fault_rd)
    );

    assign o_read_valid = r_read_valid;
    assign o_read_data  = fmm_pkg::DATA_PW'(r_read_data);

endmodule

// File: rtl/fmm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fmm_update.sv
// Per-cell fault evaluation: next stored word, next fault word and read result.
module fmm_update (
    input  logic                         i_active,
    input  logic                         i_inside,
    input  logic [fmm_pkg::FUNC_PW-1:0]  i_func,
    input  logic [fmm_pkg::WORD_BITS-1:0] i_wdata,
    input  logic [fmm_pkg::BIT_PW-1:0]   i_bit,
    input  logic [fmm_pkg::FC_W-1:0]     i_code,
    input  logic [fmm_pkg::WORD_BITS-1:0] i_stored,
    input  logic [fmm_pkg::FAULT_W-1:0]  i_faults,
    output fmm_pkg::t_upd                o_upd
);

    logic [fmm_pkg::WORD_BITS-1:0] rd_store;
    logic [fmm_pkg::WORD_BITS-1:0] rd_out;
    logic [fmm_pkg::WORD_BITS-1:0] wr_store;
    logic [fmm_pkg::FAULT_W-1:0]   new_faults;
    logic                          bit_ok;

    // Read and write effects, each cell on its own
    always_comb begin
        logic [fmm_pkg::FC_W-1:0] c;
        logic                     s;
        rd_store = i_stored;
        rd_out   = i_stored;
        wr_store = i_wdata;
        for (int i = 0; i < fmm_pkg::WORD_BITS; i++) begin
            c = i_faults[i*fmm_pkg::FC_W +: fmm_pkg::FC_W];
            s = i_stored[i];
            unique case (c)
                fmm_pkg::FC_SA0:   rd_out[i] = 1'b0;
                fmm_pkg::FC_SA1:   rd_out[i] = 1'b1;
                fmm_pkg::FC_RDF0: begin
                    rd_out[i]   = 1'b1;
                    rd_store[i] = 1'b1;
                end
                fmm_pkg::FC_RDF1: begin
                    rd_out[i]   = 1'b0;
                    rd_store[i] = 1'b0;
                end
                fmm_pkg::FC_IRF0:  rd_out[i] = 1'b1;
                fmm_pkg::FC_IRF1:  rd_out[i] = 1'b0;
                fmm_pkg::FC_DRDF0: rd_store[i] = 1'b1;
                fmm_pkg::FC_DRDF1: rd_store[i] = 1'b0;
                default:           rd_out[i] = s;
            endcase
            unique case (c)
                fmm_pkg::FC_TF_UP, fmm_pkg::FC_RDF1:   wr_store[i] = 1'b0;
                fmm_pkg::FC_TF_DOWN, fmm_pkg::FC_RDF0: wr_store[i] = 1'b1;
                default:                               wr_store[i] = i_wdata[i];
            endcase
        end
    end

    // Replace one cell's fault code
    assign bit_ok = 32'(i_bit) < fmm_pkg::WORD_BITS;

    always_comb begin
        new_faults = i_faults;
        for (int i = 0; i < fmm_pkg::WORD_BITS; i++) begin
            if (32'(i_bit) == i) begin
                new_faults[i*fmm_pkg::FC_W +: fmm_pkg::FC_W] = i_code;
            end
        end
    end

    always_comb begin
        o_upd             = '0;
        o_upd.fault_wdata = new_faults;
        o_upd.data_wdata  = wr_store;
        unique case (i_func)
            fmm_pkg::FUNC_READ: begin
                o_upd.rd_valid   = i_active;
                o_upd.rd_word    = i_inside ? rd_out : '0;
                o_upd.data_we    = i_active && i_inside;
                o_upd.data_wdata = rd_store;
            end
            fmm_pkg::FUNC_WRITE: begin
                o_upd.data_we = i_active && i_inside;
            end
            fmm_pkg::FUNC_SET_FAULT: begin
                o_upd.fault_we = i_active && i_inside && bit_ok;
            end
            default: begin
                o_upd.rd_valid = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/fmm_checker.sv
// Port-level checker for the faulty memory model, bound to the top level.
`include "faulty_memory_model_assert.svh"

module fmm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [fmm_pkg::FUNC_PW-1:0] i_func,
    input logic                        o_read_valid
);

    logic accept;
    logic rd_accept;

    assign accept    = start && !busy;
    assign rd_accept = accept && (i_func == fmm_pkg::FUNC_READ);

    // A read transaction returns its word through r_read_valid, registered at the end of the write-back
    `FMM_ASSERT_DLY(a_read_returns, i_clk, i_rst_n, rd_accept, 2, o_read_valid)
    // Writes and fault updates return nothing
    `FMM_ASSERT_DLY(a_no_spurious, i_clk, i_rst_n, accept && !rd_accept, 2, !o_read_valid)
    // Interlock: busy during the write-back after an accept
    `FMM_ASSERT_DLY(a_interlock, i_clk, i_rst_n, accept, 1, busy)
    // The write-back is over by the time its read word is strobed
    `FMM_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_read_valid, !busy)
    // The strobe lasts exactly one cycle
    `FMM_ASSERT_DLY(a_strobe_pulse, i_clk, i_rst_n, o_read_valid, 1, !o_read_valid)

endmodule

bind faulty_memory_model fmm_checker u_fmm_checker (.*);

// File: verif/tb_top.sv
// Self-checking testbench for the faulty memory model: directed fault cases, then random traffic.
`timescale 1ns / 100ps

module tb_top;
    import fmm_pkg::*;

    // Function code that the block takes and then ignores
    localparam logic [FUNC_PW-1:0] FUNC_UNUSED = 2'd3;
    // Fault codes above the last defined one are stored but act as no fault
    localparam logic [FC_W-1:0] FC_UNUSED_LO = 4'd11;
    localparam logic [FC_W-1:0] FC_UNUSED_HI = 4'd15;

    localparam int HOT_WORDS      = 16;    // small window so faults get hit often
    localparam int WATCHDOG_LIMIT = 5000;  // covers the clearing pass
    localparam int DRAIN_CYCLES   = 4;     // read data lands after the write-back of its accept
    localparam int MARCH_ITEMS    = 400;
    localparam int NOISE_ITEMS    = 100;

    typedef enum int {
        PHASE_NO_IDLE,
        PHASE_SENDER_IDLE,
        PHASE_RECEIVER_STALL,
        PHASE_BOTH_IDLE
    } idle_phase_t;

    typedef struct packed {
        logic [FUNC_PW-1:0] func;
        logic [ADDR_PW-1:0] addr;
        logic [DATA_PW-1:0] wdata;
        logic [BIT_PW-1:0]  bit_sel;
        logic [FC_W-1:0]    code;
    } mem_cmd_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_PW-1:0]  i_func;
    logic [ADDR_PW-1:0]  i_address;
    logic [DATA_PW-1:0]  i_write_data;
    logic [BIT_PW-1:0]   i_bit_index;
    logic [FC_W-1:0]     i_fault_code;
    logic                o_read_valid;
    logic [DATA_PW-1:0]  o_read_data;

    // Shadow copy of both stores, updated in transaction order
    logic [WORD_BITS-1:0] word_shadow  [WORDS];
    logic [FC_W-1:0]      fault_shadow [WORDS][WORD_BITS];

    // Read words still owed by the block, oldest first
    logic [DATA_PW-1:0]   read_data_expect_q [$];
    logic [DATA_PW-1:0]   read_data_due;

    idle_phase_t phase;
    int          idle_pct;
    int          error_count;
    int          quiet_cycles;
    int          stimulus_items;
    int          n_reads;
    int          n_writes;
    int          n_fault_sets;
    int          n_unused_codes;
    int          n_ignored;
    int          reads_checked;

    faulty_memory_model u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_bit_index  (i_bit_index),
        .i_fault_code (i_fault_code),
        .o_read_valid (o_read_valid),
        .o_read_data  (o_read_data)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow memory: work out what each accepted transaction does
    // ------------------------------------------------------------------

    function automatic mem_cmd_t make_cmd(input logic [FUNC_PW-1:0] func,
                                          input logic [ADDR_PW-1:0] addr,
                                          input logic [DATA_PW-1:0] wdata,
                                          input logic [BIT_PW-1:0]  bit_sel,
                                          input logic [FC_W-1:0]    code);
        mem_cmd_t c;
        c.func    = func;
        c.addr    = addr;
        c.wdata   = wdata;
        c.bit_sel = bit_sel;
        c.code    = code;
        return c;
    endfunction

    // Apply the transaction to the shadow stores; queue the word a read must return
    task automatic update_shadow_memory(input mem_cmd_t c);
        logic [WORD_BITS-1:0] stored;
        logic [WORD_BITS-1:0] seen;
        logic [WORD_BITS-1:0] kept;
        case (c.func)
            FUNC_READ: begin
                seen = '0;
                if (c.addr < WORDS) begin
                    stored = word_shadow[c.addr];
                    seen   = stored;
                    // Each cell acts on its own bit only; destructive reads
                    // change the cell and, for the plain kind, the returned bit
                    for (int b = 0; b < WORD_BITS; b++) begin
                        case (fault_shadow[c.addr][b])
                            FC_SA0:   seen[b] = 1'b0;
                            FC_SA1:   seen[b] = 1'b1;
                            FC_RDF0:  if (!stored[b]) begin
                                stored[b] = 1'b1;
                                seen[b]   = 1'b1;
                            end
                            FC_RDF1:  if (stored[b]) begin
                                stored[b] = 1'b0;
                                seen[b]   = 1'b0;
                            end
                            FC_IRF0:  if (!stored[b]) seen[b] = 1'b1;
                            FC_IRF1:  if (stored[b])  seen[b] = 1'b0;
                            FC_DRDF0: if (!stored[b]) stored[b] = 1'b1;
                            FC_DRDF1: if (stored[b])  stored[b] = 1'b0;
                            default: ;
                        endcase
                    end
                    word_shadow[c.addr] = stored;
                end
                read_data_expect_q.push_back(DATA_PW'(seen));
                n_reads++;
                stimulus_items++;
            end
            FUNC_WRITE: begin
                if (c.addr < WORDS) begin
                    kept = c.wdata[WORD_BITS-1:0];
                    // Transition faults and read-destructive (RDF) cells bend the written bit
                    for (int b = 0; b < WORD_BITS; b++) begin
                        case (fault_shadow[c.addr][b])
                            FC_TF_UP, FC_RDF1:   kept[b] = 1'b0;
                            FC_TF_DOWN, FC_RDF0: kept[b] = 1'b1;
                            default: ;
                        endcase
                    end
                    word_shadow[c.addr] = kept;
                end
                n_writes++;
                stimulus_items++;
            end
            FUNC_SET_FAULT: begin
                if (c.addr < WORDS && c.bit_sel < WORD_BITS)
                    fault_shadow[c.addr][c.bit_sel] = c.code;
                if (c.code >= FC_UNUSED_LO)
                    n_unused_codes++;
                n_fault_sets++;
                stimulus_items++;
            end
            default: n_ignored++;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Drop start for a random number of cycles, as the current phase asks
    task automatic sender_gap();
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Present one transaction and hold it until the block takes it. Leave start
    // high afterwards so back-to-back transactions keep it raised without a glitch.
    task automatic issue_cmd(input mem_cmd_t c);
        sender_gap();
        i_func       <= c.func;
        i_address    <= c.addr;
        i_write_data <= c.wdata;
        i_bit_index  <= c.bit_sel;
        i_fault_code <= c.code;
        start        <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        update_shadow_memory(c);
    endtask

    // Hold off new transactions until every read word owed has come back
    task automatic wait_reads_drained();
        start <= 1'b0;
        while (read_data_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly defined codes, with the unused upper range now and then
    function automatic logic [FC_W-1:0] pick_fault_code();
        if ($urandom_range(99) < 80)
            return FC_W'($urandom_range(FC_DRDF1, FC_NONE));
        return FC_W'($urandom_range(FC_UNUSED_HI, FC_UNUSED_LO));
    endfunction

    function automatic logic [DATA_PW-1:0] pick_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return DATA_PW'($urandom);
        endcase
    endfunction

    function automatic logic [ADDR_PW-1:0] pick_address(input int hot_pct);
        if ($urandom_range(99) < hot_pct)
            return ADDR_PW'($urandom_range(HOT_WORDS - 1));
        return ADDR_PW'($urandom_range(WORDS - 1));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One cell per fault kind, words chosen so every fault fires, plus the
    // ignored function and the address extremes
    task automatic test_directed_faults();
        logic [FC_W-1:0] kinds [WORD_BITS];
        kinds = '{FC_SA0, FC_SA1, FC_TF_UP, FC_TF_DOWN, FC_RDF0, FC_RDF1, FC_IRF0, FC_IRF1};
        for (int b = 0; b < WORD_BITS; b++)
            issue_cmd(make_cmd(FUNC_SET_FAULT, 10'd3, '0, BIT_PW'(b), kinds[b]));
        issue_cmd(make_cmd(FUNC_WRITE, 10'd3, 8'h55, '0, '0));
        issue_cmd(make_cmd(FUNC_READ,  10'd3, '0, '0, '0));
        issue_cmd(make_cmd(FUNC_WRITE, 10'd3, 8'hAA, '0, '0));
        issue_cmd(make_cmd(FUNC_READ,  10'd3, '0, '0, '0));
        // Deceptive reads: first read looks clean, the second one shows the flip
        issue_cmd(make_cmd(FUNC_SET_FAULT, 10'd4, '0, 3'd0, FC_DRDF0));
        issue_cmd(make_cmd(FUNC_SET_FAULT, 10'd4, '0, 3'd1, FC_DRDF1));
        issue_cmd(make_cmd(FUNC_SET_FAULT, 10'd4, '0, 3'd7, FC_UNUSED_HI));
        issue_cmd(make_cmd(FUNC_WRITE, 10'd4, 8'h82, '0, '0));
        issue_cmd(make_cmd(FUNC_READ,  10'd4, '0, '0, '0));
        issue_cmd(make_cmd(FUNC_READ,  10'd4, '0, '0, '0));
        issue_cmd(make_cmd(FUNC_UNUSED, '1, '1, '1, '1));
        issue_cmd(make_cmd(FUNC_WRITE, '1, '1, '1, '1));
        issue_cmd(make_cmd(FUNC_READ,  '1, '0, '0, '0));
        issue_cmd(make_cmd(FUNC_READ,  '0, '0, '0, '0));
    endtask

    // March-like runs on one word: plant faults, write, read back, write the
    // complement, read again. Unused fields carry random junk.
    task automatic test_march_sequences(input int n_items);
        int                 target;
        logic [ADDR_PW-1:0] a;
        logic [DATA_PW-1:0] d;
        target = stimulus_items + n_items;
        while (stimulus_items < target) begin
            a = pick_address(75);
            repeat ($urandom_range(3))
                issue_cmd(make_cmd(FUNC_SET_FAULT, a, DATA_PW'($urandom),
                                   BIT_PW'($urandom), pick_fault_code()));
            d = pick_word();
            issue_cmd(make_cmd(FUNC_WRITE, a, d, BIT_PW'($urandom), FC_W'($urandom)));
            repeat ($urandom_range(3, 1))
                issue_cmd(make_cmd(FUNC_READ, a, DATA_PW'($urandom), BIT_PW'($urandom),
                                   FC_W'($urandom)));
            issue_cmd(make_cmd(FUNC_WRITE, a, ~d, BIT_PW'($urandom), FC_W'($urandom)));
            issue_cmd(make_cmd(FUNC_READ, a, DATA_PW'($urandom), BIT_PW'($urandom),
                               FC_W'($urandom)));
        end
    endtask

    // Unordered traffic over every function, half of it in the hot window
    task automatic test_random_noise(input int n_items);
        int target;
        target = stimulus_items + n_items;
        while (stimulus_items < target)
            issue_cmd(make_cmd(FUNC_PW'($urandom_range(FUNC_UNUSED)), pick_address(50),
                               DATA_PW'($urandom), BIT_PW'($urandom), pick_fault_code()));
    endtask

    // Let the pipe empty completely, then read a word just written
    task automatic test_drain_pause();
        logic [ADDR_PW-1:0] a;
        a = pick_address(100);
        issue_cmd(make_cmd(FUNC_WRITE, a, pick_word(), '0, '0));
        wait_reads_drained();
        issue_cmd(make_cmd(FUNC_READ, a, '0, '0, '0));
        issue_cmd(make_cmd(FUNC_READ, a, '0, '0, '0));
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest word owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_read_valid === 1'b1) begin
            if (read_data_expect_q.size() == 0) begin
                $error("unexpected read result: read_data actual %0h", o_read_data);
                error_count++;
            end else begin
                read_data_due = read_data_expect_q.pop_front();
                if (o_read_data !== read_data_due) begin
                    $error("read_data mismatch: expected %0h, actual %0h",
                           read_data_due, o_read_data);
                    error_count++;
                end
                reads_checked++;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_read_valid === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = '0;
        i_address      = '0;
        i_write_data   = '0;
        i_bit_index    = '0;
        i_fault_code   = '0;
        idle_pct       = 0;
        error_count    = 0;
        quiet_cycles   = 0;
        stimulus_items = 0;
        n_reads        = 0;
        n_writes       = 0;
        n_fault_sets   = 0;
        n_unused_codes = 0;
        n_ignored      = 0;
        reads_checked  = 0;
        phase          = PHASE_NO_IDLE;
        // Both stores come out of the clearing pass as zero
        for (int w = 0; w < WORDS; w++) begin
            word_shadow[w] = '0;
            for (int b = 0; b < WORD_BITS; b++)
                fault_shadow[w][b] = FC_NONE;
        end

        // Hold reset, then release it; the clearing pass then keeps busy high
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_faults();

        // Walk through the idle settings; the receiver cannot stall, so its
        // phase runs with a steady sender and the shared one idles the sender only
        for (int p = PHASE_NO_IDLE; p <= PHASE_BOTH_IDLE; p++) begin
            phase = idle_phase_t'(p);
            case (phase)
                PHASE_SENDER_IDLE: idle_pct = 88;
                PHASE_BOTH_IDLE:   idle_pct = 10;
                default:           idle_pct = 0;
            endcase
            test_march_sequences(MARCH_ITEMS);
            test_random_noise(NOISE_ITEMS);
            if (phase == PHASE_NO_IDLE || phase == PHASE_BOTH_IDLE)
                test_drain_pause();
        end

        // Drain outstanding reads, then allow a few cycles for stray strobes
        wait_reads_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d reads, %0d writes, %0d fault updates (%0d with unused codes), %0d ignored",
                 n_reads, n_writes, n_fault_sets, n_unused_codes, n_ignored);
        $display("Checked %0d read words across four sender idle settings", reads_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
